// ----- hw/rtl/sparse_voxel_octree_builder_top_assert.svh -----
// Assertion macros used by the top-level RTL file
`ifndef SPARSE_VOXEL_OCTREE_BUILDER_TOP_ASSERT_SVH
`define SPARSE_VOXEL_OCTREE_BUILDER_TOP_ASSERT_SVH
// same-cycle implication
`define SVOB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("svob assertion failed");
// next-cycle implication
`define SVOB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("svob assertion failed");
`endif

// ----- hw/rtl/svob_pkg.sv -----
`default_nettype none
package svob_pkg;
  localparam int LEVELS     = 8;
  localparam int INDEX_BITS = 16;
  localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};

  // configuration register byte addresses
  localparam logic [2:0] REG_LEVEL_COUNT = 3'd0;

  // one node descriptor as held in a level queue
  typedef struct packed {
    logic [INDEX_BITS-1:0] base;
    logic [7:0]            valid;
    logic [7:0]            leaf;
  } desc_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic push;
    logic shift;
    logic clear;
  } cell_ctl_t;
endpackage
`default_nettype wire

// ----- hw/rtl/svob_cell.sv -----
`default_nettype none
// One tree level: an eight-entry queue that shifts its head out on flush
module svob_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire svob_pkg::cell_ctl_t ctl,
  input  wire svob_pkg::desc_t   push_desc,
  output svob_pkg::desc_t        head,
  output logic                   full
);
  svob_pkg::desc_t q [8];
  logic [3:0]      fill;

  // queue storage: write at fill point, shift towards the head
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      for (int k = 0; k < 7; k++) q[k] <= q[k+1];
    end else if (ctl.push) begin
      q[fill[2:0]] <= push_desc;
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      fill <= 4'd0;
    end else if (ctl.push) begin
      fill <= fill + 4'd1;
    end
  end

  assign head = q[0];
  assign full = fill[3];
endmodule
`default_nettype wire

// ----- hw/rtl/sparse_voxel_octree_builder_top.sv -----
// An item that fills no queue gives no word unless level_count is zero, when the
// root descriptor is sent. Each flushed level passes the check state and then walks
// its eight entries, one entry per cycle while the output does not stall.
// One item at a time: in_stall stays high until the sequencer is back in idle.
// Reset (rst, synchronous): queues empty, store index zero, level_count 7.
`default_nettype none
module sparse_voxel_octree_builder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  block_occupancy,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             descriptor_kind,
  output logic [15:0]      store_index,
  output logic [15:0]      child_base,
  output logic [7:0]       valid_bits,
  output logic [7:0]       leaf_bits,
  output logic             index_overflow,
  output logic             last_of_run
);
`include "sparse_voxel_octree_builder_top_assert.svh"

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CHECK  = 2'd1;
  localparam logic [1:0] ST_FLUSH  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  typedef struct packed {
    logic                  kind;
    logic [15:0]           idx;
    svob_pkg::desc_t       desc;
    logic                  ovf;
  } res_t;

  logic [1:0]  state;
  logic [2:0]  level_count;
  logic [2:0]  d;
  logic [2:0]  i;
  logic [16:0] nsi;
  logic        ovf_seen;
  logic [15:0] fbase;
  logic [7:0]  acc_valid, acc_leaf;
  logic        pend_valid;
  res_t        pend;

  svob_pkg::cell_ctl_t ctl   [svob_pkg::LEVELS];
  svob_pkg::desc_t     pdesc [svob_pkg::LEVELS];
  svob_pkg::desc_t     head  [svob_pkg::LEVELS];
  logic                full  [svob_pkg::LEVELS];

  // configuration port
  assign pready = 1'b1;
  assign prdata = {29'd0, level_count};
  always_ff @(posedge clk) begin
    if (rst) begin
      level_count <= 3'd7;
    end else if (psel && penable && pwrite && paddr == svob_pkg::REG_LEVEL_COUNT) begin
      level_count <= pwdata[2:0];
    end
  end

  // row of level cells
  for (genvar g = 0; g < svob_pkg::LEVELS; g++) begin : g_cell
    svob_cell u_cell (
      .clk(clk), .rst(rst), .ctl(ctl[g]), .push_desc(pdesc[g]),
      .head(head[g]), .full(full[g])
    );
  end

  // flush entry classification
  svob_pkg::desc_t e;
  logic e_nonempty, e_solid, e_store;
  assign e          = head[d];
  assign e_nonempty = e.valid != 8'd0;
  assign e_solid    = e.valid == 8'hFF && e.leaf == 8'hFF;
  assign e_store    = e_nonempty && !e_solid;

  logic out_free, can_new;
  assign out_free = !out_valid || !out_stall;
  assign can_new  = !pend_valid || out_free;

  logic in_acc;
  assign in_stall = state != ST_IDLE;
  assign in_acc   = in_valid && !in_stall;

  logic       new_fire, root_fire, flush_step, finish_fire;
  res_t       new_res;
  logic [7:0] bit_i, nvalid, nleaf;
  assign bit_i  = 8'd1 << i;
  assign nvalid = acc_valid | (e_nonempty ? bit_i : 8'd0);
  assign nleaf  = acc_leaf  | (e_solid    ? bit_i : 8'd0);

  always_comb begin
    flush_step  = state == ST_FLUSH && (!e_store || can_new);
    root_fire   = state == ST_CHECK && d == 3'd0 && can_new;
    finish_fire = state == ST_FINISH && pend_valid && out_free;
    new_fire    = root_fire || (flush_step && e_store);
    new_res     = '0;
    if (root_fire) begin
      new_res.kind = 1'b1;
      new_res.desc = head[0];
      new_res.ovf  = ovf_seen;
    end else begin
      new_res.idx  = nsi[16] ? svob_pkg::INDEX_MAX : nsi[15:0];
      new_res.desc = e;
      new_res.ovf  = ovf_seen | nsi[16];
    end
  end

  // cell control
  always_comb begin
    for (int k = 0; k < svob_pkg::LEVELS; k++) begin
      ctl[k]   = '0;
      pdesc[k] = '0;
      if (root_fire) ctl[k].clear = 1'b1;
      if (in_acc && level_count == k[2:0]) begin
        ctl[k].push = 1'b1;
        pdesc[k]    = '{base: 16'd0, valid: block_occupancy, leaf: block_occupancy};
      end
      if (flush_step && d == k[2:0]) begin
        ctl[k].shift = 1'b1;
        if (i == 3'd7) ctl[k].clear = 1'b1;
      end
      if (flush_step && i == 3'd7 && d == k[2:0] + 3'd1) begin
        ctl[k].push = 1'b1;
        pdesc[k]    = '{base: fbase, valid: nvalid, leaf: nleaf};
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      nsi      <= 17'd0;
      ovf_seen <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            d     <= level_count;
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (d != 3'd0 && full[d]) begin
            i         <= 3'd0;
            acc_valid <= 8'd0;
            acc_leaf  <= 8'd0;
            fbase     <= nsi[16] ? svob_pkg::INDEX_MAX : nsi[15:0];
            state     <= ST_FLUSH;
          end else if (d != 3'd0) begin
            state <= ST_FINISH;
          end else if (root_fire) begin
            nsi      <= 17'd0;
            ovf_seen <= 1'b0;
            state    <= ST_FINISH;
          end
        end
        ST_FLUSH: begin
          if (flush_step) begin
            acc_valid <= nvalid;
            acc_leaf  <= nleaf;
            i         <= i + 3'd1;
            if (e_store) begin
              if (nsi[16]) ovf_seen <= 1'b1;
              else nsi <= nsi + 17'd1;
            end
            if (i == 3'd7) begin
              d     <= d - 3'd1;
              state <= ST_CHECK;
            end
          end
        end
        ST_FINISH: begin
          if (!pend_valid || out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // one-word hold-back so the last word of an item can be marked
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (new_fire) begin
        pend       <= new_res;
        pend_valid <= 1'b1;
      end else if (finish_fire) begin
        pend_valid <= 1'b0;
      end
      if ((new_fire && pend_valid) || finish_fire) begin
        out_valid       <= 1'b1;
        descriptor_kind <= pend.kind;
        store_index     <= pend.idx;
        child_base      <= pend.desc.base;
        valid_bits      <= pend.desc.valid;
        leaf_bits       <= pend.desc.leaf;
        index_overflow  <= pend.ovf;
        last_of_run     <= finish_fire;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `SVOB_ASSERT_NOW(a_flush_level, state == ST_FLUSH, d != 3'd0)
  `SVOB_ASSERT_NOW(a_idle_drained, state == ST_IDLE, !pend_valid)
  `SVOB_ASSERT_NEXT(a_accept_check, in_acc, state == ST_CHECK)
  `SVOB_ASSERT_NOW(a_index_bound, 1'b1, nsi <= 17'h10000)
endmodule
`default_nettype wire
